### rtl/core/atapio_pkg.sv
// ----------------------------------------------------------------------------
// atapio_pkg
// Shared constants and types for the ATA PIO LBA28 task-file device.
// ----------------------------------------------------------------------------
package atapio_pkg;

  // Medium geometry (SECTOR_WORDS must be a power of two)
  localparam int MEDIUM_SECTORS = 64;
  localparam int SECTOR_WORDS   = 256;
  localparam int MEDIUM_WORDS   = MEDIUM_SECTORS * SECTOR_WORDS;
  localparam int WORD_AW        = $clog2(SECTOR_WORDS);
  localparam int SECT_AW        = (MEDIUM_SECTORS > 1) ? $clog2(MEDIUM_SECTORS) : 1;
  localparam int MEM_AW         = SECT_AW + WORD_AW;
  // LBA bits that survive the 32-bit slot computation
  localparam int SLOT_LBA_W     = 32 - WORD_AW;

  // Access kind
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Task file offsets
  localparam logic [2:0] OFS_DATA    = 3'd0;
  localparam logic [2:0] OFS_ERROR   = 3'd1;
  localparam logic [2:0] OFS_COUNT   = 3'd2;
  localparam logic [2:0] OFS_LBA_LO  = 3'd3;
  localparam logic [2:0] OFS_LBA_MID = 3'd4;
  localparam logic [2:0] OFS_LBA_HI  = 3'd5;
  localparam logic [2:0] OFS_DRVHEAD = 3'd6;
  localparam logic [2:0] OFS_STATUS  = 3'd7;

  // Status and error bits
  localparam logic [7:0] ST_DRDY = 8'h40;
  localparam logic [7:0] ST_DRQ  = 8'h08;
  localparam logic [7:0] ST_ERR  = 8'h01;
  localparam logic [7:0] ER_ABRT = 8'h04;
  localparam logic [7:0] ER_IDNF = 8'h10;

  // Commands
  localparam logic [7:0] CMD_READ  = 8'h20;
  localparam logic [7:0] CMD_WRITE = 8'h30;

  // Reset values
  localparam logic [7:0] COUNT_RESET   = 8'h01;
  localparam logic [7:0] DRVHEAD_RESET = 8'hA0;

  // Sector transfer direction
  typedef enum logic [2:0] {
    XFER_IDLE = 3'b001,
    XFER_RD   = 3'b010,
    XFER_WR   = 3'b100
  } xfer_t;

  // Block control
  typedef enum logic [2:0] {
    CTL_CLEAR = 3'b001,
    CTL_RUN   = 3'b010,
    CTL_WAIT  = 3'b100
  } ctl_t;

endpackage

### rtl/core/ata_pio_lba28_device_unit.sv
// ----------------------------------------------------------------------------
// ata_pio_lba28_device_unit
// Device side of an ATA task file in PIO mode with single-sector transfers.
// ----------------------------------------------------------------------------
// After reset the block clears its medium, one word per cycle, writing all
// MEDIUM_SECTORS*SECTOR_WORDS words, and holds in_stall high meanwhile.
// It then takes one bus access per cycle while in_stall is low; a data
// read during a sector read goes through the registered medium read and a
// wait state that holds in_stall high. Each access returns exactly one word
// on the output channel, which is a single register, so a stalled result
// holds off the next request until it is taken.
module ata_pio_lba28_device_unit
  import atapio_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [2:0]  reg_offset,
  input  logic [15:0] write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] read_data
);

  localparam logic [MEM_AW-1:0] CLR_LAST = MEM_AW'(MEDIUM_WORDS - 1);

  ctl_t                ctl;
  logic [MEM_AW-1:0]   clr_addr;
  logic [7:0]          sector_count;
  logic [27:0]         lba_address;
  logic [7:0]          drive_head;
  logic [7:0]          status_bits;
  logic [7:0]          error_bits;
  logic [WORD_AW-1:0]  word_index;
  xfer_t               transfer_mode;

  logic [15:0]         medium_mem [MEDIUM_WORDS];
  logic [15:0]         mem_q;
  logic                mem_we;
  logic [MEM_AW-1:0]   mem_waddr;
  logic [15:0]         mem_wdata;
  logic [MEM_AW-1:0]   slot_addr;

  logic                accept;
  logic                drq;
  logic                data_rd;
  logic                data_wr;
  logic                last_word;
  logic [7:0]          wr_byte;
  logic [7:0]          reg_byte;
  logic                bad_dh;
  logic                bad_cmd;
  logic                bad_lba;

  // Handshake and decode
  assign in_stall  = (ctl != CTL_RUN) || (out_valid && out_stall);
  assign accept    = in_valid && !in_stall;
  assign drq       = (status_bits & ST_DRQ) != 8'd0;
  assign data_rd   = (op == OP_READ) && (reg_offset == OFS_DATA) && drq &&
                     (transfer_mode == XFER_RD);
  assign data_wr   = (op == OP_WRITE) && (reg_offset == OFS_DATA) && drq &&
                     (transfer_mode == XFER_WR);
  assign last_word = word_index == WORD_AW'(SECTOR_WORDS - 1);
  assign wr_byte   = write_data[7:0];

  // Command checks
  assign bad_dh  = !drive_head[6] || drive_head[4];
  assign bad_cmd = (wr_byte != CMD_READ) && (wr_byte != CMD_WRITE);
  assign bad_lba = lba_address >= 28'(MEDIUM_SECTORS);

  // Map LBA and word to a medium slot; out-of-range slots fold to word zero
  always_comb begin
    if (lba_address[SLOT_LBA_W-1:0] < SLOT_LBA_W'(MEDIUM_SECTORS)) begin
      slot_addr = {lba_address[SECT_AW-1:0], word_index};
    end else begin
      slot_addr = '0;
    end
  end

  // Memory port select: clear pass owns the write port until done
  assign mem_we    = (ctl == CTL_CLEAR) || (accept && data_wr);
  assign mem_waddr = (ctl == CTL_CLEAR) ? clr_addr : slot_addr;
  assign mem_wdata = (ctl == CTL_CLEAR) ? 16'd0 : write_data;

  // Medium storage, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      medium_mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= medium_mem[slot_addr];
  end

  // Register read mux
  always_comb begin
    unique case (reg_offset)
      OFS_ERROR:   reg_byte = error_bits;
      OFS_COUNT:   reg_byte = sector_count;
      OFS_LBA_LO:  reg_byte = lba_address[7:0];
      OFS_LBA_MID: reg_byte = lba_address[15:8];
      OFS_LBA_HI:  reg_byte = lba_address[23:16];
      OFS_DRVHEAD: reg_byte = drive_head;
      default:     reg_byte = status_bits;
    endcase
  end

  // Control sequencer: clear pass, run, wait for medium read data
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl      <= CTL_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (ctl)
        CTL_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == CLR_LAST) begin
            ctl <= CTL_RUN;
          end
        end
        CTL_RUN: begin
          if (accept && data_rd) begin
            ctl <= CTL_WAIT;
          end
        end
        default: begin
          ctl <= CTL_RUN;
        end
      endcase
    end
  end

  // Task file state update
  always_ff @(posedge clk) begin
    if (rst) begin
      sector_count  <= COUNT_RESET;
      lba_address   <= '0;
      drive_head    <= DRVHEAD_RESET;
      status_bits   <= ST_DRDY;
      error_bits    <= '0;
      word_index    <= '0;
      transfer_mode <= XFER_IDLE;
    end else if (accept) begin
      if (data_rd || data_wr) begin
        // Advance through the sector, close it after the last word
        if (last_word) begin
          word_index    <= '0;
          transfer_mode <= XFER_IDLE;
          status_bits   <= ST_DRDY;
        end else begin
          word_index <= word_index + 1'b1;
        end
      end else if (op == OP_WRITE) begin
        unique case (reg_offset)
          OFS_COUNT:   sector_count <= wr_byte;
          OFS_LBA_LO:  lba_address[7:0] <= wr_byte;
          OFS_LBA_MID: lba_address[15:8] <= wr_byte;
          OFS_LBA_HI:  lba_address[23:16] <= wr_byte;
          OFS_DRVHEAD: begin
            drive_head         <= wr_byte;
            lba_address[27:24] <= wr_byte[3:0];
          end
          OFS_STATUS: begin
            // Run a command: abort any transfer, then check in order
            word_index <= '0;
            priority if (bad_dh || bad_cmd) begin
              transfer_mode <= XFER_IDLE;
              status_bits   <= ST_DRDY | ST_ERR;
              error_bits    <= ER_ABRT;
            end else if (bad_lba) begin
              transfer_mode <= XFER_IDLE;
              status_bits   <= ST_DRDY | ST_ERR;
              error_bits    <= ER_IDNF;
            end else begin
              transfer_mode <= (wr_byte == CMD_READ) ? XFER_RD : XFER_WR;
              status_bits   <= ST_DRDY | ST_DRQ;
              error_bits    <= '0;
            end
          end
          default: begin
            // Drop data writes outside a transfer and features writes
          end
        endcase
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((accept && !data_rd) || (ctl == CTL_WAIT)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl == CTL_WAIT) begin
      read_data <= mem_q;
    end else if (accept && !data_rd) begin
      if ((op == OP_WRITE) || (reg_offset == OFS_DATA)) begin
        read_data <= 16'd0;
      end else begin
        read_data <= {8'd0, reg_byte};
      end
    end
  end

endmodule

### rtl/core/atapio_checker.sv
// ----------------------------------------------------------------------------
// atapio_checker
// Port-level checks for the ATA PIO task-file device, bound to the top level.
// ----------------------------------------------------------------------------
module atapio_checker
  import atapio_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        op,
  input logic [2:0]  reg_offset,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] read_data
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data))
    else $error("result changed while stalled");

  // Keep requests out during the medium clear pass
  a_clear_stall: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("request taken during clear pass");

  // Answer every write request with zero in the next cycle
  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    in_acc && (op == OP_WRITE) |=> out_valid && (read_data == 16'd0))
    else $error("write request result is not zero");

  // Answer register reads at once with a byte value
  a_reg_byte: assert property (@(posedge clk) disable iff (rst)
    in_acc && (op == OP_READ) && (reg_offset != OFS_DATA)
      |=> out_valid && (read_data[15:8] == 8'd0))
    else $error("register read result malformed");

  // Show status with DRDY set and BSY clear
  a_status: assert property (@(posedge clk) disable iff (rst)
    in_acc && (op == OP_READ) && (reg_offset == OFS_STATUS)
      |=> read_data[7:6] == 2'b01)
    else $error("status read without DRDY or with BSY");

endmodule

bind ata_pio_lba28_device_unit atapio_checker u_atapio_checker (.*);
